// ===== hw/rtl/dq_pkg.sv =====
// Package for the double-ended byte queue.
// Holds the request and response structs and the opcode and status codes.
// Depends on nothing; used by double_ended_queue.
`timescale 1ns / 1ps
`default_nettype none

package dq_pkg;

  // Opcodes of a request
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_REAR   = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT = 3'd4;
  localparam logic [2:0] OP_PEEK_REAR  = 3'd5;

  // Status codes of a response
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] push_byte;
  } dq_req_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic [4:0] occupancy;
  } dq_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/double_ended_queue.sv =====
// Top level of the double-ended byte queue: ring memory, head pointer, count.
// Depends on dq_pkg (request/response structs, opcode and status codes).
//
//  channel   | ports                | handshake
//  ----------+----------------------+-------------------------------------
//  request   | start, busy, req     | taken at a clock edge with start & !busy
//  response  | done, rsp            | one cycle, marked by done, no stall
//
// Every request is answered in the cycle after it is taken, with done high for
// a single cycle. A request can be taken every cycle; busy stays low since
// the head and count update at the accept edge and the single-ported ring
// memory (one write or one read per request) never conflicts.
// Reset (rst, synchronous) empties the queue at once; memory contents are
// left as they are. The receiver cannot stall responses.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire dq_req_t req,
  output logic         done,
  output dq_rsp_t      rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] CNT_CAP  = CNT_W'(CAPACITY);
  localparam logic [SUM_W-1:0] SUM_CAP  = SUM_W'(CAPACITY);
  localparam logic [4:0]       OCC_CAP  = 5'(CAPACITY);

  // Queue state
  logic [7:0]       mem [CAPACITY];
  logic [IDX_W-1:0] head, head_next;
  logic [CNT_W-1:0] count, count_next;

  // Response stage
  logic [7:0]       rd_data;
  logic             use_rd;
  logic [1:0]       status;
  logic [CNT_W-1:0] occ;
  logic [CNT_W+4:0] occ_ext;

  // Per-request decode
  logic             accept;
  logic             empty, full;
  logic [IDX_W-1:0] head_dec, head_inc, tail, rear;
  logic [SUM_W-1:0] tail_sum;
  logic             mem_we, mem_re;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [1:0]       status_next;

  assign busy   = 1'b0;
  assign accept = start & ~busy;
  assign empty  = (count == '0);
  assign full   = (count == CNT_CAP);

  // Ring pointer arithmetic; tail is one past the rear entry
  assign head_dec = (head == '0) ? IDX_LAST : head - IDX_W'(1);
  assign head_inc = (head == IDX_LAST) ? '0 : head + IDX_W'(1);
  assign tail_sum = SUM_W'(head) + SUM_W'(count);
  assign tail     = (tail_sum >= SUM_CAP) ? IDX_W'(tail_sum - SUM_CAP)
                                          : IDX_W'(tail_sum);
  assign rear     = (tail == '0) ? IDX_LAST : tail - IDX_W'(1);

  // Operation decode: memory access, pointer/count update, status
  always_comb begin
    head_next   = head;
    count_next  = count;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    wr_addr     = tail;
    rd_addr     = head;
    status_next = ST_OK;
    unique case (req.opcode)
      OP_PUSH_FRONT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          wr_addr    = head_dec;
          head_next  = head_dec;
          count_next = count + CNT_W'(1);
        end
      end
      OP_PUSH_REAR: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          mem_we     = 1'b1;
          wr_addr    = tail;
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP_FRONT, OP_PEEK_FRONT: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_re  = 1'b1;
          rd_addr = head;
          if (req.opcode == OP_POP_FRONT) begin
            head_next  = head_inc;
            count_next = count - CNT_W'(1);
          end
        end
      end
      OP_POP_REAR, OP_PEEK_REAR: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          mem_re  = 1'b1;
          rd_addr = rear;
          if (req.opcode == OP_POP_REAR) begin
            count_next = count - CNT_W'(1);
          end
        end
      end
      default: begin
        // unused opcodes do nothing
      end
    endcase
  end

  // Ring memory, one access per request, registered read
  always_ff @(posedge clk) begin
    if (accept && mem_we) begin
      mem[wr_addr] <= req.push_byte;
    end
    if (accept && mem_re) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Pointer, count and response strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= accept;
      if (accept) begin
        head  <= head_next;
        count <= count_next;
      end
    end
  end

  // Response payload
  always_ff @(posedge clk) begin
    if (accept) begin
      use_rd <= mem_re;
      status <= status_next;
      occ    <= count_next;
    end
  end

  assign occ_ext       = {5'b0, occ};
  assign rsp.out_byte  = use_rd ? rd_data : 8'd0;
  assign rsp.status    = status;
  assign rsp.occupancy = occ_ext[4:0];

  // Checks
  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept))
    else $error("response without a request");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_CAP)
    else $error("count beyond capacity");

  a_empty_rsp: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_EMPTY) |-> (rsp.occupancy == 5'd0 && rsp.out_byte == 8'd0))
    else $error("empty response carries data or occupancy");

  a_full_rsp: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status == ST_FULL) |-> (rsp.occupancy == OCC_CAP && rsp.out_byte == 8'd0))
    else $error("full response with wrong occupancy");

endmodule

`default_nettype wire
